>>> rtl/core/tas_pkg.sv
// Package for the three-axis accelerometer smoother.
// Holds the fixed field widths, register indexes, reset values and the
// controller-to-datapath command word. No dependencies.
package tas_pkg;

   localparam int COEFF_W     = 16;
   localparam int COEFF_SHIFT = 16;
   localparam int GAIN_W      = 16;
   localparam int GAIN_SHIFT  = 12;
   localparam int DEADBAND_W  = 13;
   localparam int OUT_W       = 14;
   localparam int OUT_MAX     = 8191;
   localparam int OUT_MIN     = -8192;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_IDX_W   = 2;

   localparam int RST_FILTER_COEFF = 66;
   localparam int RST_ZERO_LEVEL   = 1862;
   localparam int RST_GAIN         = 11000;
   localparam int RST_DEADBAND     = 80;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FILTER_COEFF = 2'd0,
      CSR_ZERO_LEVEL   = 2'd1,
      CSR_GAIN         = 2'd2,
      CSR_DEADBAND     = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_PEND
   } ctl_state_type;

   typedef struct packed {
      logic accept;    // take a word and form the filter products
      logic update;    // fold the filter products into the state
      logic ps_load;   // form the gain products from the state
      logic out_load;  // saturate, apply deadband, load the result register
   } dp_cmd_type;

endpackage

>>> rtl/core/tas_chan_if.sv
// Request and response channel interfaces of the accelerometer smoother.
// Valid/ready handshake; request sample width is the SAMPLE_BITS parameter, results are 14-bit signed.
interface tas_req_if #(parameter int SAMPLE_BITS = 12);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample_x;
   logic [SAMPLE_BITS-1:0] sample_y;
   logic [SAMPLE_BITS-1:0] sample_z;

   modport source (output valid, output sample_x, output sample_y, output sample_z,
                   input ready);
   modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                   output ready);
endinterface

interface tas_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [13:0] accel_x;
   logic signed [13:0] accel_y;
   logic signed [13:0] accel_z;

   modport source (output valid, output accel_x, output accel_y, output accel_z,
                   input ready);
   modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                   output ready);
endinterface

>>> rtl/core/three_axis_accel_smoother.sv
// Three-axis accelerometer smoother: per-axis low-pass filter, gain to milli-g,
// saturation and deadband. A taken word passes the filter product, state update,
// gain product and result registers in that order. The next word is taken only
// after the state update, when the gain stage is free; back-pressure stalls it.
// Reset (synchronous): filter state to zero, registers to defaults, no result held.
// Depends on tas_pkg, tas_chan_if, tas_ctrl and tas_datapath.
module three_axis_accel_smoother
   import tas_pkg::*;
#(
   parameter int SAMPLE_BITS   = 12,
   parameter int FRACTION_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   tas_req_if.sink               req_if,
   tas_rsp_if.source             rsp_if,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type cmd;

   tas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   tas_datapath #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .sample_x  (req_if.sample_x),
      .sample_y  (req_if.sample_y),
      .sample_z  (req_if.sample_z),
      .accel_x   (rsp_if.accel_x),
      .accel_y   (rsp_if.accel_y),
      .accel_z   (rsp_if.accel_z)
   );

endmodule

>>> rtl/core/tas_ctrl.sv
// Controller of the accelerometer smoother: sequences filter update and
// scaling, tracks the scale and result stages. Depends on tas_pkg.
module tas_ctrl
   import tas_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd
);

   ctl_state_type state_ff, state_in;
   logic          ps_v_ff, ps_v_in;
   logic          out_v_ff, out_v_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ps_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ps_v_ff  <= ps_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd.out_load = ps_v_ff && (!out_v_ff || rsp_ready);
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_PEND;
         end
         ST_PEND: begin
            // the state must be read by the gain stage before the next update
            cmd.ps_load = !ps_v_ff || cmd.out_load;
            req_ready   = cmd.ps_load;
            if (req_valid && cmd.ps_load) begin
               cmd.accept = 1'b1;
               state_in   = ST_UPDATE;
            end else if (cmd.ps_load) begin
               state_in = ST_IDLE;
            end
         end
      endcase
      ps_v_in  = cmd.ps_load ? 1'b1 : (cmd.out_load ? 1'b0 : ps_v_ff);
      out_v_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : out_v_ff);
   end

   assign rsp_valid = out_v_ff;

endmodule

>>> rtl/core/tas_datapath.sv
// Datapath of the accelerometer smoother: config registers, three filter
// lanes, gain scaling, saturation and deadband. Depends on tas_pkg.
module tas_datapath
   import tas_pkg::*;
#(
   parameter int SAMPLE_BITS   = 12,
   parameter int FRACTION_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              cmd,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic [SAMPLE_BITS-1:0]  sample_x,
   input  logic [SAMPLE_BITS-1:0]  sample_y,
   input  logic [SAMPLE_BITS-1:0]  sample_z,
   output logic signed [OUT_W-1:0] accel_x,
   output logic signed [OUT_W-1:0] accel_y,
   output logic signed [OUT_W-1:0] accel_z
);

   localparam int ST_W        = SAMPLE_BITS + FRACTION_BITS;
   localparam int DIFF_W      = ST_W + 1;
   localparam int FPROD_W     = DIFF_W + COEFF_W + 1;
   localparam int SPROD_W     = DIFF_W + GAIN_W + 1;
   localparam int SCALE_SHIFT = FRACTION_BITS + GAIN_SHIFT;

   logic [COEFF_W-1:0]     coeff_ff;
   logic [SAMPLE_BITS-1:0] zero_ff;
   logic [GAIN_W-1:0]      gain_ff;
   logic [DEADBAND_W-1:0]  deadband_ff;

   logic [SAMPLE_BITS-1:0]      sample [3];
   logic [ST_W-1:0]             filt_ff [3];
   logic [ST_W-1:0]             filt_in [3];
   logic signed [FPROD_W-1:0]   fprod_ff [3];
   logic signed [FPROD_W-1:0]   fprod_in [3];
   logic signed [SPROD_W-1:0]   sprod_ff [3];
   logic signed [SPROD_W-1:0]   sprod_in [3];
   logic signed [OUT_W-1:0]     accel_ff [3];
   logic signed [OUT_W-1:0]     accel_in [3];

   assign sample[0] = sample_x;
   assign sample[1] = sample_y;
   assign sample[2] = sample_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff    <= COEFF_W'(RST_FILTER_COEFF);
         zero_ff     <= SAMPLE_BITS'(RST_ZERO_LEVEL);
         gain_ff     <= GAIN_W'(RST_GAIN);
         deadband_ff <= DEADBAND_W'(RST_DEADBAND);
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_FILTER_COEFF: coeff_ff    <= csr_wdata[COEFF_W-1:0];
            CSR_ZERO_LEVEL:   zero_ff     <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_GAIN:         gain_ff     <= csr_wdata[GAIN_W-1:0];
            CSR_DEADBAND:     deadband_ff <= csr_wdata[DEADBAND_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (reset) begin
            filt_ff[i] <= '0;
         end else if (cmd.update) begin
            filt_ff[i] <= filt_in[i];
         end
         if (cmd.accept) begin
            fprod_ff[i] <= fprod_in[i];
         end
         if (cmd.ps_load) begin
            sprod_ff[i] <= sprod_in[i];
         end
         if (cmd.out_load) begin
            accel_ff[i] <= accel_in[i];
         end
      end
   end

   always_comb begin
      logic signed [DIFF_W-1:0]  diff;
      logic signed [FPROD_W-1:0] fstep;
      logic signed [DIFF_W-1:0]  sdiff;
      logic signed [SPROD_W-1:0] scaled;
      logic signed [OUT_W-1:0]   sat;
      logic [OUT_W-1:0]          mag;
      for (int i = 0; i < 3; i++) begin
         // filter product: (sample - state) * coeff
         diff = signed'({1'b0, sample[i], {FRACTION_BITS{1'b0}}})
              - signed'({1'b0, filt_ff[i]});
         fprod_in[i] = FPROD_W'(diff) * FPROD_W'(signed'({1'b0, coeff_ff}));

         // floored step never exceeds the difference, so it fits DIFF_W
         fstep      = fprod_ff[i] >>> COEFF_SHIFT;
         filt_in[i] = ST_W'(signed'({1'b0, filt_ff[i]}) + signed'(fstep[DIFF_W-1:0]));

         sdiff = signed'({1'b0, filt_ff[i]})
               - signed'({1'b0, zero_ff, {FRACTION_BITS{1'b0}}});
         sprod_in[i] = SPROD_W'(sdiff) * SPROD_W'(signed'({1'b0, gain_ff}));

         scaled = sprod_ff[i] >>> SCALE_SHIFT;
         if (scaled > SPROD_W'(OUT_MAX)) begin
            sat = OUT_W'(OUT_MAX);
         end else if (scaled < SPROD_W'(OUT_MIN)) begin
            sat = OUT_W'(OUT_MIN);
         end else begin
            sat = scaled[OUT_W-1:0];
         end
         // magnitude of the most negative value still reads right as unsigned
         mag         = sat[OUT_W-1] ? OUT_W'(-sat) : OUT_W'(sat);
         accel_in[i] = (mag < {1'b0, deadband_ff}) ? '0 : sat;
      end
   end

   assign accel_x = accel_ff[0];
   assign accel_y = accel_ff[1];
   assign accel_z = accel_ff[2];

endmodule
